### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

### sv/mhc_pkg.sv
// ----------------------------------------------------------------------------
// Countdown bank package
// Types and constants shared by the countdown channel ring.
// ----------------------------------------------------------------------------
package mhc_pkg;

    localparam int HRS_W   = 7;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int MEL_W   = 8;
    localparam int CNT_W   = 8;
    localparam int IDX_W   = 4;
    localparam int MASK_W  = 12;

    localparam logic [SEC_W-1:0] TIME_MAX   = 6'd59;
    localparam logic [SEC_W-1:0] RESET_SEC0 = 6'd5;

    typedef enum logic [2:0] {
        OP_SET_TIME   = 3'd0,
        OP_START      = 3'd1,
        OP_STOP       = 3'd2,
        OP_TICK       = 3'd3,
        OP_READ       = 3'd4,
        OP_CLEAR_PEND = 3'd5,
        OP_SET_MELODY = 3'd6
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic [HRS_W-1:0] now_hours;
        logic [MIN_W-1:0] now_minutes;
        logic [SEC_W-1:0] now_seconds;
        logic [HRS_W-1:0] start_hours;
        logic [MIN_W-1:0] start_minutes;
        logic [SEC_W-1:0] start_seconds;
        logic             run;
        logic [MEL_W-1:0] melody;
    } t_chan;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] index;
        logic             tick_en;
        logic [HRS_W-1:0] hours;
        logic [MIN_W-1:0] minutes;
        logic [SEC_W-1:0] seconds;
        logic [MEL_W-1:0] melody;
    } t_cmd;

endpackage

### sv/mhc_cell.sv
// ----------------------------------------------------------------------------
// Countdown channel cell
// Holds one channel's state and passes it to its neighbor while the ring turns.
// ----------------------------------------------------------------------------
module mhc_cell import mhc_pkg::*; #(
    parameter logic [SEC_W-1:0] RESET_SECONDS = 6'd0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_chan i_d,
    output t_chan o_q
);

    localparam t_chan RESET_CHAN = '{
        now_hours:     '0,
        now_minutes:   '0,
        now_seconds:   RESET_SECONDS,
        start_hours:   '0,
        start_minutes: '0,
        start_seconds: '0,
        run:           1'b0,
        melody:        '0
    };

    t_chan r_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= RESET_CHAN;
        end else if (i_shift) begin
            r_chan <= i_d;
        end
    end

    assign o_q = r_chan;

endmodule

### sv/mhc_update.sv
// ----------------------------------------------------------------------------
// Countdown channel update
// Applies the current command to the channel leaving the ring head.
// ----------------------------------------------------------------------------
module mhc_update import mhc_pkg::*; (
    input  t_chan            i_chan,
    input  t_cmd             i_cmd,
    input  logic             i_hit,
    input  logic [CNT_W-1:0] i_count,
    output t_chan            o_chan,
    output logic             o_expired,
    output logic [CNT_W-1:0] o_count
);

    logic halt;

    always_comb begin
        o_chan    = i_chan;
        o_expired = 1'b0;
        halt      = 1'b0;
        o_count   = i_count;
        if (i_cmd.op == OP_TICK) begin
            if (i_cmd.tick_en && i_chan.run) begin
                if (i_chan.now_seconds != '0) begin
                    o_chan.now_seconds = i_chan.now_seconds - 1'b1;
                end else begin
                    o_chan.now_seconds = TIME_MAX;
                    if (i_chan.now_minutes != '0) begin
                        o_chan.now_minutes = i_chan.now_minutes - 1'b1;
                    end else begin
                        o_chan.now_minutes = TIME_MAX;
                        if (i_chan.now_hours != '0) begin
                            o_chan.now_hours = i_chan.now_hours - 1'b1;
                        end else begin
                            halt      = 1'b1;
                            o_expired = 1'b1;
                        end
                    end
                end
            end
        end else if (i_hit) begin
            unique case (i_cmd.op)
                OP_SET_TIME: begin
                    o_chan.now_hours     = i_cmd.hours;
                    o_chan.now_minutes   = i_cmd.minutes;
                    o_chan.now_seconds   = i_cmd.seconds;
                    o_chan.start_hours   = i_cmd.hours;
                    o_chan.start_minutes = i_cmd.minutes;
                    o_chan.start_seconds = i_cmd.seconds;
                end
                OP_START: begin
                    o_chan.run = 1'b1;
                    o_count    = i_count + 1'b1;
                end
                OP_STOP: begin
                    halt = 1'b1;
                end
                OP_SET_MELODY: begin
                    o_chan.melody = i_cmd.melody;
                end
                default: begin
                end
            endcase
        end
        if (halt) begin
            o_chan.run         = 1'b0;
            o_chan.now_hours   = i_chan.start_hours;
            o_chan.now_minutes = i_chan.start_minutes;
            o_chan.now_seconds = i_chan.start_seconds;
            if (i_count != '0) begin
                o_count = i_count - 1'b1;
            end
        end
    end

endmodule

### sv/multi_channel_hms_countdown_top.sv
// ----------------------------------------------------------------------------
// Countdown timer bank
// Ring of hours:minutes:seconds countdown channels driven by one command port.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Fields
//  command   in         start / busy     op, index, hours, minutes, seconds, melody_in
//  result    out        o_done strobe    expired_mask, pending, count, channel fields
//
// Every beat turns the channel ring once, one channel passing the update unit
// per cycle, and the result follows in the next cycle.
// Reset is synchronous and active low; it loads all channels at once.
// Results appear for one cycle with o_done; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_channel_hms_countdown_top import mhc_pkg::*; #(
    parameter int CHANNELS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_op,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [HRS_W-1:0]  i_hours,
    input  logic [MIN_W-1:0]  i_minutes,
    input  logic [SEC_W-1:0]  i_seconds,
    input  logic [MEL_W-1:0]  i_melody_in,
    output logic              o_done,
    output logic [MASK_W-1:0] o_expired_mask,
    output logic              o_pending_valid,
    output logic [IDX_W-1:0]  o_pending_index,
    output logic [CNT_W-1:0]  o_running_count,
    output logic [HRS_W-1:0]  o_cur_hours,
    output logic [MIN_W-1:0]  o_cur_minutes,
    output logic [SEC_W-1:0]  o_cur_seconds,
    output logic              o_is_running,
    output logic [MEL_W-1:0]  o_melody_out
);

    localparam int STEP_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CHANNELS - 1);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step;
    t_cmd                r_cmd;
    logic [CNT_W-1:0]    r_count;
    logic                r_pending_flag;
    logic [IDX_W-1:0]    r_pending_ch;
    logic [MASK_W-1:0]   r_mask;
    t_chan               r_cur;
    logic                r_done;

    t_chan               q [CHANNELS];
    t_chan               upd_chan;
    logic                upd_expired;
    logic [CNT_W-1:0]    upd_count;
    logic                shift;
    logic                accept;
    logic                hit;
    logic                last;
    logic [MASK_W-1:0]   step_onehot;
    logic [MIN_W-1:0]    min_clamped;
    logic [SEC_W-1:0]    sec_clamped;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_ring
        localparam logic [SEC_W-1:0] RS = (g == 0) ? RESET_SEC0 : 6'd0;
        t_chan d;
        if (g == CHANNELS - 1) begin : g_tail
            assign d = upd_chan;
        end else begin : g_mid
            assign d = q[g+1];
        end
        mhc_cell #(
            .RESET_SECONDS(RS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(shift),
            .i_d    (d),
            .o_q    (q[g])
        );
    end

    assign hit = ({1'b0, r_cmd.index} < (IDX_W+1)'(CHANNELS))
              && (r_cmd.index == IDX_W'(r_step));

    mhc_update u_update (
        .i_chan   (q[0]),
        .i_cmd    (r_cmd),
        .i_hit    (hit),
        .i_count  (r_count),
        .o_chan   (upd_chan),
        .o_expired(upd_expired),
        .o_count  (upd_count)
    );

    assign accept      = start && !busy;
    assign last        = (r_step == LAST_STEP);
    assign step_onehot = MASK_W'(1) << r_step;
    assign min_clamped = (i_minutes > TIME_MAX) ? TIME_MAX : i_minutes;
    assign sec_clamped = (i_seconds > TIME_MAX) ? TIME_MAX : i_seconds;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy  = (r_state == ST_WALK);
        shift = (r_state == ST_WALK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_step         <= '0;
            r_count        <= '0;
            r_pending_flag <= 1'b0;
            r_pending_ch   <= '0;
            r_done         <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= shift && last;
            if (accept) begin
                r_step <= '0;
                if (t_op'(i_op) == OP_CLEAR_PEND) begin
                    r_pending_flag <= 1'b0;
                end
            end else if (shift) begin
                r_step  <= last ? '0 : r_step + 1'b1;
                r_count <= upd_count;
                if (upd_expired) begin
                    r_pending_flag <= 1'b1;
                    r_pending_ch   <= IDX_W'(r_step);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op      <= t_op'(i_op);
            r_cmd.index   <= i_index;
            r_cmd.tick_en <= (r_count != '0);
            r_cmd.hours   <= i_hours;
            r_cmd.minutes <= min_clamped;
            r_cmd.seconds <= sec_clamped;
            r_cmd.melody  <= i_melody_in;
            r_mask        <= '0;
            r_cur         <= '0;
        end else if (shift) begin
            if (upd_expired) begin
                r_mask <= r_mask | step_onehot;
            end
            if (hit) begin
                r_cur <= upd_chan;
            end
        end
    end

    assign o_done          = r_done;
    assign o_expired_mask  = r_mask;
    assign o_pending_valid = r_pending_flag;
    assign o_pending_index = r_pending_flag ? r_pending_ch : '0;
    assign o_running_count = r_count;
    assign o_cur_hours     = r_cur.now_hours;
    assign o_cur_minutes   = r_cur.now_minutes;
    assign o_cur_seconds   = r_cur.now_seconds;
    assign o_is_running    = r_cur.run;
    assign o_melody_out    = r_cur.melody;

    `ASSERT_NEXT(a_accept_walks, i_clk, i_rst_n, accept, busy)
    `ASSERT_NEXT(a_last_step_done, i_clk, i_rst_n, busy && last, o_done && !busy)
    `ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, o_done, !busy && (r_step == '0))
    `ASSERT_SAME(a_mask_only_tick, i_clk, i_rst_n, o_done && (r_cmd.op != OP_TICK),
        o_expired_mask == '0)

endmodule

### bench/multi_channel_hms_countdown_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer bank testbench
// Drives command beats through the start / busy port and keeps its own model
// of the twelve channels, the shared started count and the pending expiry.
// Every o_done result is checked field by field against the oldest predicted
// beat. Directed checks cover reset values, clamping, out-of-range channels,
// the unused op code, duplicate starts, stops, expiry order and count wrap;
// random traffic then runs mostly short countdowns so that expiries are common.
// ----------------------------------------------------------------------------
module multi_channel_hms_countdown_top_tb import mhc_pkg::*;;

    localparam int CHANNELS = 12;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct {
        logic [MASK_W-1:0] expired_mask;
        logic              pending_valid;
        logic [IDX_W-1:0]  pending_index;
        logic [CNT_W-1:0]  running_count;
        logic [HRS_W-1:0]  hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
        logic              running;
        logic [MEL_W-1:0]  melody;
    } t_countdown_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        i_op;
    logic [IDX_W-1:0]  i_index;
    logic [HRS_W-1:0]  i_hours;
    logic [MIN_W-1:0]  i_minutes;
    logic [SEC_W-1:0]  i_seconds;
    logic [MEL_W-1:0]  i_melody_in;
    logic              o_done;
    logic [MASK_W-1:0] o_expired_mask;
    logic              o_pending_valid;
    logic [IDX_W-1:0]  o_pending_index;
    logic [CNT_W-1:0]  o_running_count;
    logic [HRS_W-1:0]  o_cur_hours;
    logic [MIN_W-1:0]  o_cur_minutes;
    logic [SEC_W-1:0]  o_cur_seconds;
    logic              o_is_running;
    logic [MEL_W-1:0]  o_melody_out;

    logic [HRS_W-1:0]  now_hrs   [CHANNELS];
    logic [MIN_W-1:0]  now_min   [CHANNELS];
    logic [SEC_W-1:0]  now_sec   [CHANNELS];
    logic [HRS_W-1:0]  load_hrs  [CHANNELS];
    logic [MIN_W-1:0]  load_min  [CHANNELS];
    logic [SEC_W-1:0]  load_sec  [CHANNELS];
    logic              run_flag  [CHANNELS];
    logic [MEL_W-1:0]  melody_no [CHANNELS];
    logic [CNT_W-1:0]  started_count;
    logic              pend_flag;
    logic [IDX_W-1:0]  pend_chan;

    t_countdown_result expected_results[$];
    int                error_count = 0;

    multi_channel_hms_countdown_top #(
        .CHANNELS(CHANNELS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_index        (i_index),
        .i_hours        (i_hours),
        .i_minutes      (i_minutes),
        .i_seconds      (i_seconds),
        .i_melody_in    (i_melody_in),
        .o_done         (o_done),
        .o_expired_mask (o_expired_mask),
        .o_pending_valid(o_pending_valid),
        .o_pending_index(o_pending_index),
        .o_running_count(o_running_count),
        .o_cur_hours    (o_cur_hours),
        .o_cur_minutes  (o_cur_minutes),
        .o_cur_seconds  (o_cur_seconds),
        .o_is_running   (o_is_running),
        .o_melody_out   (o_melody_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("[multi_channel_hms_countdown_top] ERROR");
        $finish;
    end

    function automatic void bank_reset();
        for (int c = 0; c < CHANNELS; c++) begin
            now_hrs[c]   = '0;
            now_min[c]   = '0;
            now_sec[c]   = '0;
            load_hrs[c]  = '0;
            load_min[c]  = '0;
            load_sec[c]  = '0;
            run_flag[c]  = 1'b0;
            melody_no[c] = '0;
        end
        now_sec[0]    = RESET_SEC0;
        started_count = '0;
        pend_flag     = 1'b0;
        pend_chan     = '0;
    endfunction

    function automatic void halt_chan(input int c);
        run_flag[c] = 1'b0;
        now_hrs[c]  = load_hrs[c];
        now_min[c]  = load_min[c];
        now_sec[c]  = load_sec[c];
        if (started_count != 0)
            started_count = started_count - 1'b1;
    endfunction

    // Returns 1 when the channel counts below zero and expires.
    function automatic bit count_down_chan(input int c);
        if (!run_flag[c])
            return 1'b0;
        if (now_sec[c] != 0) begin
            now_sec[c] = now_sec[c] - 1'b1;
            return 1'b0;
        end
        now_sec[c] = TIME_MAX;
        if (now_min[c] != 0) begin
            now_min[c] = now_min[c] - 1'b1;
            return 1'b0;
        end
        now_min[c] = TIME_MAX;
        if (now_hrs[c] != 0) begin
            now_hrs[c] = now_hrs[c] - 1'b1;
            return 1'b0;
        end
        halt_chan(c);
        return 1'b1;
    endfunction

    function automatic void bank_apply(
        input  logic [2:0]        op,
        input  logic [IDX_W-1:0]  idx,
        input  logic [HRS_W-1:0]  h,
        input  logic [MIN_W-1:0]  m,
        input  logic [SEC_W-1:0]  s,
        input  logic [MEL_W-1:0]  mel,
        output t_countdown_result r
    );
        logic [MIN_W-1:0]  m_c;
        logic [SEC_W-1:0]  s_c;
        logic [MASK_W-1:0] mask;
        bit                ok;

        ok   = (idx < CHANNELS);
        m_c  = (m > TIME_MAX) ? TIME_MAX : m;
        s_c  = (s > TIME_MAX) ? TIME_MAX : s;
        mask = '0;
        case (op)
            OP_SET_TIME: begin
                if (ok) begin
                    now_hrs[idx] = h;   load_hrs[idx] = h;
                    now_min[idx] = m_c; load_min[idx] = m_c;
                    now_sec[idx] = s_c; load_sec[idx] = s_c;
                end
            end
            OP_START: begin
                if (ok) begin
                    started_count = started_count + 1'b1;
                    run_flag[idx] = 1'b1;
                end
            end
            OP_STOP: begin
                if (ok)
                    halt_chan(idx);
            end
            OP_TICK: begin
                if (started_count != 0) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (count_down_chan(c)) begin
                            mask[c]   = 1'b1;
                            pend_flag = 1'b1;
                            pend_chan = c[IDX_W-1:0];
                        end
                    end
                end
            end
            OP_CLEAR_PEND: pend_flag = 1'b0;
            OP_SET_MELODY: begin
                if (ok)
                    melody_no[idx] = mel;
            end
            default: ;
        endcase

        r.expired_mask  = mask;
        r.pending_valid = pend_flag;
        r.pending_index = pend_flag ? pend_chan : '0;
        r.running_count = started_count;
        if (ok) begin
            r.hours   = now_hrs[idx];
            r.minutes = now_min[idx];
            r.seconds = now_sec[idx];
            r.running = run_flag[idx];
            r.melody  = melody_no[idx];
        end else begin
            r.hours   = '0;
            r.minutes = '0;
            r.seconds = '0;
            r.running = 1'b0;
            r.melody  = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_beat(
        input logic [2:0]       op,
        input logic [IDX_W-1:0] idx,
        input logic [HRS_W-1:0] h,
        input logic [MIN_W-1:0] m,
        input logic [SEC_W-1:0] s,
        input logic [MEL_W-1:0] mel
    );
        t_countdown_result r;
        @(negedge i_clk);
        start       <= 1'b1;
        i_op        <= op;
        i_index     <= idx;
        i_hours     <= h;
        i_minutes   <= m;
        i_seconds   <= s;
        i_melody_in <= mel;
        do @(posedge i_clk); while (busy !== 1'b0);
        bank_apply(op, idx, h, m, s, mel, r);
        expected_results.push_back(r);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_countdown_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_expired_mask !== want.expired_mask)
                    report_mismatch("expired_mask", o_expired_mask, want.expired_mask);
                if (o_pending_valid !== want.pending_valid)
                    report_mismatch("pending_valid", o_pending_valid, want.pending_valid);
                if (o_pending_index !== want.pending_index)
                    report_mismatch("pending_index", o_pending_index, want.pending_index);
                if (o_running_count !== want.running_count)
                    report_mismatch("running_count", o_running_count, want.running_count);
                if (o_cur_hours !== want.hours)
                    report_mismatch("cur_hours", o_cur_hours, want.hours);
                if (o_cur_minutes !== want.minutes)
                    report_mismatch("cur_minutes", o_cur_minutes, want.minutes);
                if (o_cur_seconds !== want.seconds)
                    report_mismatch("cur_seconds", o_cur_seconds, want.seconds);
                if (o_is_running !== want.running)
                    report_mismatch("is_running", o_is_running, want.running);
                if (o_melody_out !== want.melody)
                    report_mismatch("melody_out", o_melody_out, want.melody);
            end
        end
    end

    task automatic test_reset_and_edges();
        send_beat(OP_READ, 4'd0, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_READ, 4'd15, 7'd127, 6'd63, 6'd63, 8'd255);
        send_beat(OP_UNUSED, 4'd3, 7'd5, 6'd5, 6'd5, 8'd5);
        send_beat(OP_SET_MELODY, 4'd11, 7'd0, 6'd0, 6'd0, 8'd255);
        send_beat(OP_SET_MELODY, 4'd12, 7'd0, 6'd0, 6'd0, 8'd77);
        send_beat(OP_SET_MELODY, 4'd11, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_SET_TIME, 4'd1, 7'd127, 6'd63, 6'd60, 8'd0);
        send_beat(OP_SET_TIME, 4'd13, 7'd9, 6'd9, 6'd9, 8'd0);
        send_beat(OP_TICK, 4'd1, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_STOP, 4'd5, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_SET_TIME, 4'd1, 7'd0, 6'd0, 6'd0, 8'd0);
    endtask

    task automatic test_start_stop_expiry();
        send_beat(OP_START, 4'd2, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_TICK, 4'd2, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_TICK, 4'd2, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_SET_TIME, 4'd0, 7'd0, 6'd0, 6'd1, 8'd0);
        send_beat(OP_SET_TIME, 4'd11, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_START, 4'd0, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_START, 4'd11, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_TICK, 4'd11, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_TICK, 4'd0, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_CLEAR_PEND, 4'd0, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_START, 4'd4, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_START, 4'd4, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_STOP, 4'd4, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_TICK, 4'd4, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_STOP, 4'd4, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_SET_TIME, 4'd6, 7'd1, 6'd0, 6'd0, 8'd0);
        send_beat(OP_START, 4'd6, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_TICK, 4'd6, 7'd0, 6'd0, 6'd0, 8'd0);
        send_beat(OP_SET_TIME, 4'd6, 7'd0, 6'd0, 6'd2, 8'd0);
        send_beat(OP_STOP, 4'd6, 7'd0, 6'd0, 6'd0, 8'd0);
    endtask

    task automatic test_count_wrap();
        for (int n = 0; n < 260; n++)
            send_beat(OP_START, 4'($urandom_range(0, CHANNELS - 1)), 7'd0, 6'd0, 6'd0, 8'd0);
        for (int c = 0; c < CHANNELS; c++)
            send_beat(OP_STOP, 4'(c), 7'd0, 6'd0, 6'd0, 8'd0);
    endtask

    task automatic random_beat();
        logic [2:0]       op;
        logic [IDX_W-1:0] idx;
        logic [HRS_W-1:0] h;
        logic [MIN_W-1:0] m;
        logic [SEC_W-1:0] s;
        int               r;

        r = $urandom_range(99);
        if (r < 35)      op = OP_TICK;
        else if (r < 50) op = OP_SET_TIME;
        else if (r < 62) op = OP_START;
        else if (r < 70) op = OP_STOP;
        else if (r < 78) op = OP_READ;
        else if (r < 84) op = OP_CLEAR_PEND;
        else if (r < 94) op = OP_SET_MELODY;
        else             op = OP_UNUSED;
        idx = ($urandom_range(9) == 0) ? 4'($urandom_range(12, 15))
                                       : 4'($urandom_range(0, CHANNELS - 1));
        h = ($urandom_range(6) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 1));
        m = ($urandom_range(4) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 2));
        s = ($urandom_range(3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 4));
        send_beat(op, idx, h, m, s, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic();
        bit back_to_back;
        back_to_back = 1'b0;
        for (int n = 0; n < 1300; n++) begin
            if (n % 200 == 0)
                back_to_back = ~back_to_back;
            if (n == 800) begin
                idle_gap(1);
                wait_drained();
            end
            random_beat();
            if (!back_to_back)
                idle_gap(pick_gap());
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_op        = OP_READ;
        i_index     = '0;
        i_hours     = '0;
        i_minutes   = '0;
        i_seconds   = '0;
        i_melody_in = '0;
        bank_reset();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_and_edges();
        test_start_stop_expiry();
        test_count_wrap();
        test_random_traffic();

        idle_gap(1);
        wait_drained();
        repeat (CHANNELS + 4) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[multi_channel_hms_countdown_top] OK");
        end else begin
            $display("[multi_channel_hms_countdown_top] ERROR");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/mhc_pkg.sv
sv/mhc_cell.sv
sv/mhc_update.sv
sv/multi_channel_hms_countdown_top.sv
bench/multi_channel_hms_countdown_top_tb.sv
